// ===== design/u8d_pkg.sv =====
// u8d_pkg: shared types, constants and decode helpers for the utf-8 decoder
// depends on nothing; imported by every module of the decoder
`default_nettype none

package u8d_pkg;

  localparam int CpW = 21;

  // lead classification masks and patterns
  localparam logic [7:0] AsciiMask = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;

  // payload masks
  localparam logic [7:0] Pay2Mask  = 8'h1F;
  localparam logic [7:0] Pay3Mask  = 8'h0F;
  localparam logic [7:0] Pay4Mask  = 8'h07;
  localparam logic [7:0] ContMask  = 8'h3F;
  localparam logic [7:0] AsciiPay  = 8'h7F;

  // sequence lengths
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenOne  = 3'd1;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThr  = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  // one queue entry: up to two code points caused by one input beat
  typedef struct packed {
    logic           has_pt;
    logic           two_pt;
    logic           eot;
    logic [CpW-1:0] pt0;
    logic [CpW-1:0] pt1;
  } u8d_rec_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] l;
    if ((b & AsciiMask) == 8'h00)        l = LenOne;
    else if ((b & Lead2Mask) == Lead2Pat) l = LenTwo;
    else if ((b & Lead3Mask) == Lead3Pat) l = LenThr;
    else if ((b & Lead4Mask) == Lead4Pat) l = LenFour;
    else                                  l = LenNone;
    return l;
  endfunction

  function automatic logic [CpW-1:0] asm1(input logic [7:0] b0);
    return {13'd0, b0 & AsciiPay};
  endfunction

  function automatic logic [CpW-1:0] asm2(input logic [7:0] b0, input logic [7:0] b1);
    logic [7:0] p0, p1;
    p0 = b0 & Pay2Mask;
    p1 = b1 & ContMask;
    return {10'd0, p0[4:0], p1[5:0]};
  endfunction

  function automatic logic [CpW-1:0] asm3(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2);
    logic [7:0] p0, p1, p2;
    p0 = b0 & Pay3Mask;
    p1 = b1 & ContMask;
    p2 = b2 & ContMask;
    return {5'd0, p0[3:0], p1[5:0], p2[5:0]};
  endfunction

  function automatic logic [CpW-1:0] asm4(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3);
    logic [7:0] p0, p1, p2, p3;
    p0 = b0 & Pay4Mask;
    p1 = b1 & ContMask;
    p2 = b2 & ContMask;
    p3 = b3 & ContMask;
    return {p0[2:0], p1[5:0], p2[5:0], p3[5:0]};
  endfunction

endpackage

`default_nettype wire

// ===== design/u8d_front.sv =====
// u8d_front: accepts byte beats, tracks the open sequence, builds queue entries
// depends on u8d_pkg
`default_nettype none

module u8d_front
  import u8d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] byte_value,
  input  wire logic       end_of_text,
  output u8d_rec_t        rec,
  output logic            push
);

  logic [7:0] held_r [3];
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [2:0] seq_len_r, seq_len_nxt;

  logic [7:0]     buf0, buf1, buf2;
  logic [2:0]     need, n_cnt, len_byte, len_h1;
  logic           fits, hold;
  logic [CpW-1:0] full_pt;

  // gathered bytes with the new byte placed after the held ones
  assign buf0 = (held_cnt_r == 2'd0) ? byte_value : held_r[0];
  assign buf1 = (held_cnt_r == 2'd1) ? byte_value : held_r[1];
  assign buf2 = (held_cnt_r == 2'd2) ? byte_value : held_r[2];

  assign need     = (held_cnt_r == 2'd0) ? lead_len(byte_value) : seq_len_r;
  assign n_cnt    = {1'b0, held_cnt_r} + 3'd1;
  assign fits     = (need != LenNone) && (n_cnt >= need);
  assign hold     = (need != LenNone) && !fits && !end_of_text;
  assign len_byte = lead_len(byte_value);
  assign len_h1   = lead_len(held_r[1]);

  // assemble a complete sequence
  always_comb begin
    case (need)
      LenOne:  full_pt = asm1(buf0);
      LenTwo:  full_pt = asm2(buf0, buf1);
      LenThr:  full_pt = asm3(buf0, buf1, buf2);
      LenFour: full_pt = asm4(buf0, buf1, buf2, byte_value);
      default: full_pt = '0;
    endcase
  end

  // result record, including re-parse of a truncated tail at end of text
  always_comb begin
    rec     = '0;
    rec.eot = end_of_text;
    if (fits) begin
      rec.has_pt = 1'b1;
      rec.pt0    = full_pt;
    end else if ((need != LenNone) && end_of_text) begin
      case (held_cnt_r)
        2'd1: begin
          if (len_byte == LenOne) begin
            rec.has_pt = 1'b1;
            rec.pt0    = asm1(byte_value);
          end
        end
        2'd2: begin
          if (len_h1 == LenOne) begin
            rec.has_pt = 1'b1;
            rec.pt0    = asm1(held_r[1]);
            if (len_byte == LenOne) begin
              rec.two_pt = 1'b1;
              rec.pt1    = asm1(byte_value);
            end
          end else if (len_h1 == LenTwo) begin
            rec.has_pt = 1'b1;
            rec.pt0    = asm2(held_r[1], byte_value);
          end else if (len_byte == LenOne) begin
            rec.has_pt = 1'b1;
            rec.pt0    = asm1(byte_value);
          end
        end
        default: ;
      endcase
    end
  end

  assign push = accept && (rec.has_pt || end_of_text);

  // sequence tracking
  always_comb begin
    held_cnt_nxt = held_cnt_r;
    seq_len_nxt  = seq_len_r;
    if (accept) begin
      if (hold) begin
        held_cnt_nxt = held_cnt_r + 2'd1;
        seq_len_nxt  = need;
      end else begin
        held_cnt_nxt = 2'd0;
        seq_len_nxt  = LenNone;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      seq_len_r  <= LenNone;
    end else begin
      held_cnt_r <= held_cnt_nxt;
      seq_len_r  <= seq_len_nxt;
    end
  end

  // held byte store, no reset
  always_ff @(posedge clk) begin
    if (accept && hold) begin
      case (held_cnt_r)
        2'd0:    held_r[0] <= byte_value;
        2'd1:    held_r[1] <= byte_value;
        2'd2:    held_r[2] <= byte_value;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/u8d_queue.sv =====
// u8d_queue: two-entry queue of result records between front and back
// depends on u8d_pkg
`default_nettype none

module u8d_queue
  import u8d_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire u8d_rec_t push_rec,
  input  wire logic     pop,
  output u8d_rec_t      head,
  output logic          not_empty,
  output logic          full
);

  u8d_rec_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

// ===== design/u8d_back.sv =====
// u8d_back: splits queue records into single result beats, output register
// depends on u8d_pkg
`default_nettype none

module u8d_back
  import u8d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire u8d_rec_t   head,
  input  wire logic       not_empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [CpW-1:0]  out_code_point,
  output logic            out_has_point,
  output logic            out_run_final,
  output logic            out_text_done
);

  logic           valid_r, valid_nxt;
  logic           sub_r, sub_nxt;
  logic [CpW-1:0] cp_r;
  logic           has_r, fin_r, done_r;
  logic           load, last_of_rec;
  logic [CpW-1:0] sel_cp;
  logic           sel_has, sel_fin, sel_done;

  assign load        = not_empty && (!valid_r || out_ready);
  assign last_of_rec = sub_r || !head.two_pt;
  assign pop         = load && last_of_rec;

  // pick the first or second point of the head record
  always_comb begin
    if (sub_r) begin
      sel_cp   = head.pt1;
      sel_has  = 1'b1;
      sel_fin  = 1'b1;
      sel_done = head.eot;
    end else begin
      sel_cp   = head.pt0;
      sel_has  = head.has_pt;
      sel_fin  = !head.two_pt;
      sel_done = head.eot && !head.two_pt;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    sub_nxt   = sub_r;
    if (load) begin
      valid_nxt = 1'b1;
      sub_nxt   = !last_of_rec;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= sel_cp;
      has_r  <= sel_has;
      fin_r  <= sel_fin;
      done_r <= sel_done;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_point = cp_r;
  assign out_has_point  = has_r;
  assign out_run_final  = fin_r;
  assign out_text_done  = done_r;

endmodule

`default_nettype wire

// ===== design/utf8_byte_stream_decoder.sv =====
// utf8_byte_stream_decoder: lenient streaming utf-8 decoder, top level
// depends on u8d_pkg, u8d_front, u8d_queue, u8d_back
//
//   channel | signals                                             | per beat
//   --------+-----------------------------------------------------+------------------
//   in      | in_valid in_ready in_byte_value in_end_of_text      | one text byte
//   out     | out_valid out_ready out_code_point out_has_point    | one result
//           | out_run_final out_text_done                         |
//
// one byte beat is taken per cycle while the record queue is not full; results
// leave one per cycle while out_ready is high, so a byte that yields two code
// points takes two result beats; byte path: front record, queue, output register.
// in_ready drops only while the two-entry record queue is full.
// reset is synchronous, active low, and clears the open sequence and queue.
`default_nettype none

module utf8_byte_stream_decoder
  import u8d_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte_value,
  input  wire logic           in_end_of_text,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [CpW-1:0]      out_code_point,
  output logic                out_has_point,
  output logic                out_run_final,
  output logic                out_text_done
);

  u8d_rec_t rec, head;
  logic     accept, push, pop, not_empty, full;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  u8d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .byte_value  (in_byte_value),
    .end_of_text (in_end_of_text),
    .rec         (rec),
    .push        (push)
  );

  u8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (rec),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  u8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .not_empty      (not_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_has_point  (out_has_point),
    .out_run_final  (out_run_final),
    .out_text_done  (out_text_done)
  );

endmodule

`default_nettype wire

// ===== design/u8d_checker.sv =====
// u8d_checker: port-level checks on the decoder's result channel, bound to top
// depends on u8d_pkg and utf8_byte_stream_decoder
`default_nettype none

module u8d_checker
  import u8d_pkg::*;
(
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire logic [CpW-1:0] out_code_point,
  input wire logic           out_has_point,
  input wire logic           out_run_final,
  input wire logic           out_text_done
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point) &&
    $stable(out_has_point) && $stable(out_run_final) && $stable(out_text_done))
    else $error("result beat changed while stalled");

  // empty marker carries a zero code point
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_point |-> out_code_point == '0)
    else $error("empty result with nonzero code point");

  // end of text closes the byte's run
  a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_done |-> out_run_final)
    else $error("text_done without run_final");

  // an empty result only ever marks end of text
  a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_point |-> out_text_done && out_run_final)
    else $error("empty result outside end of text");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_u8d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_code_point (out_code_point),
  .out_has_point  (out_has_point),
  .out_run_final  (out_run_final),
  .out_text_done  (out_text_done)
);

`default_nettype wire

// ===== dv/tb_utf8_byte_stream_decoder.sv =====
`timescale 1ns / 1ps
// tb_utf8_byte_stream_decoder: self-checking testbench for the lenient utf-8 decoder
// drives byte beats with random gaps and output backpressure, predicts each result with a
// local decoder model; depends on u8d_pkg and utf8_byte_stream_decoder

module tb_utf8_byte_stream_decoder;
  import u8d_pkg::*;

  localparam int IdleLimit    = 2000;
  localparam int RandomItems  = 1320;
  localparam int LongHold     = 120;
  localparam int SettleCycles = 6;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           has_point;
    logic           run_final;
    logic           text_done;
  } cp_result_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [7:0]     in_byte_value = 8'h00;
  logic           in_end_of_text = 1'b0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [CpW-1:0] out_code_point;
  logic           out_has_point;
  logic           out_run_final;
  logic           out_text_done;

  // open sequence as the predictor sees it
  logic [7:0] pend_bytes [3];
  int         pend_count = 0;
  int         pend_len = 0;

  cp_result_t expected_points [$];
  logic [7:0] text_buf [$];
  int         errors = 0;
  int         random_items = 0;
  int         idle_cycles = 0;
  bit         tx_nogap = 1'b0;
  bit         rx_nogap = 1'b0;
  bit         long_hold_req = 1'b0;

  utf8_byte_stream_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_value  (in_byte_value),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_has_point  (out_has_point),
    .out_run_final  (out_run_final),
    .out_text_done  (out_text_done)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // sequence length a lead byte announces, zero for a stray byte
  function automatic int lead_bytes(input logic [7:0] b);
    if ((b & AsciiMask) == 8'h00) return 1;
    if ((b & Lead2Mask) == Lead2Pat) return 2;
    if ((b & Lead3Mask) == Lead3Pat) return 3;
    if ((b & Lead4Mask) == Lead4Pat) return 4;
    return 0;
  endfunction

  // payload bits of a sequence, following bytes taken unchecked
  function automatic logic [CpW-1:0] join_bytes(input logic [7:0] b0, input logic [7:0] b1,
                                                 input logic [7:0] b2, input logic [7:0] b3,
                                                 input int len);
    case (len)
      2:       return {10'd0, b0[4:0], b1[5:0]};
      3:       return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      4:       return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: return {14'd0, b0[6:0]};
    endcase
  endfunction

  // advance the decoder state by one byte and queue the code points it yields
  function automatic void predict_byte(input logic [7:0] b, input logic eot);
    logic [7:0]     seq [7];
    logic [CpW-1:0] pts [2];
    int             n, need, np, i, len;
    cp_result_t     r;
    for (i = 0; i < 7; i++) seq[i] = 8'h00;
    for (i = 0; i < pend_count; i++) seq[i] = pend_bytes[i];
    seq[pend_count] = b;
    n = pend_count + 1;
    need = (pend_count == 0) ? lead_bytes(b) : pend_len;
    np = 0;
    if (need != 0 && n >= need) begin
      pts[0] = join_bytes(seq[0], seq[1], seq[2], seq[3], need);
      np = 1;
    end else if (need != 0 && eot) begin
      // text ends mid-sequence: drop the lead, parse what follows it again
      i = 1;
      while (i < n) begin
        len = lead_bytes(seq[i]);
        if (len == 0 || i + len > n || np >= 2) begin
          i++;
        end else begin
          pts[np] = join_bytes(seq[i], seq[i+1], seq[i+2], seq[i+3], len);
          np++;
          i += len;
        end
      end
    end
    if (need != 0 && n < need && !eot) begin
      for (i = 0; i < n; i++) pend_bytes[i] = seq[i];
      pend_count = n;
      pend_len = need;
    end else begin
      pend_count = 0;
      pend_len = 0;
    end
    // a final byte always gives a result, empty if nothing decoded
    if (np == 0 && eot) begin
      r.code_point = '0;
      r.has_point = 1'b1 ^ 1'b1;
      r.run_final = 1'b1;
      r.text_done = 1'b1;
      expected_points = {expected_points, r};
    end
    for (i = 0; i < np; i++) begin
      r.code_point = pts[i];
      r.has_point = 1'b1;
      r.run_final = (i == np - 1);
      r.text_done = (i == np - 1) && eot;
      expected_points = {expected_points, r};
    end
  endfunction

  // offer one byte beat and wait for it to be taken
  task automatic send_beat(input logic [7:0] b, input logic eot);
    int gap;
    gap = tx_nogap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_byte(b, eot);
  endtask

  // send the buffered text, end flag on its last byte
  task automatic send_text();
    int i;
    for (i = 0; i < text_buf.size(); i++) send_beat(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // sender goes quiet until every expected result is out
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // following byte: mostly a proper continuation, sometimes anything
  function automatic logic [7:0] follow_byte();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h80, 8'hBF));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] lead_of(input int len);
    case (len)
      1:       return 8'($urandom_range(8'h00, 8'h7F));
      2:       return 8'($urandom_range(8'hC0, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  function automatic void add_char(input int len);
    int k;
    text_buf = {text_buf, lead_of(len)};
    for (k = 1; k < len; k++) text_buf = {text_buf, follow_byte()};
  endfunction

  // lead with too few following bytes, any values, to end a text
  function automatic void add_truncated();
    int len, k;
    len = $urandom_range(2, 4);
    text_buf = {text_buf, lead_of(len)};
    for (k = $urandom_range(0, len - 2); k > 0; k--)
      text_buf = {text_buf, 8'($urandom_range(0, 255))};
  endfunction

  task automatic test_ascii_extremes();
    text_buf = '{8'h00, 8'h7F};
    send_text();
    wait_drain();
  endtask

  task automatic test_multibyte_extremes();
    text_buf = '{8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'hBF, 8'hF7, 8'hBF, 8'h80, 8'hBF};
    send_text();
    wait_drain();
  endtask

  // stray bytes dropped, continuation top bits ignored, empty final result
  task automatic test_stray_bytes();
    text_buf = '{8'h80, 8'hF8, 8'hC3, 8'h41, 8'hFF};
    send_text();
    wait_drain();
  endtask

  // lead as final byte, truncated sequences parsed again at end of text
  task automatic test_truncated_end();
    text_buf = '{8'hC3};
    send_text();
    text_buf = '{8'hF0, 8'h41, 8'h42};
    send_text();
    text_buf = '{8'hF0, 8'hC3, 8'hA9};
    send_text();
    wait_drain();
  endtask

  // back-to-back beats with the sink always ready
  task automatic test_full_rate();
    int i;
    tx_nogap = 1'b1;
    rx_nogap = 1'b1;
    for (i = 0; i < 12; i++) add_char($urandom_range(1, 4));
    send_text();
    tx_nogap = 1'b0;
    rx_nogap = 1'b0;
    wait_drain();
  endtask

  // sink holds off for a long stretch while beats keep coming
  task automatic test_output_backpressure();
    int i;
    long_hold_req = 1'b1;
    tx_nogap = 1'b1;
    for (i = 0; i < 16; i++) add_char($urandom_range(1, 2));
    send_text();
    tx_nogap = 1'b0;
    wait_drain();
  endtask

  // mostly well-formed texts with random content, some truncated, some noise
  task automatic test_random_text();
    int kind, chars, i;
    while (random_items < RandomItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        chars = $urandom_range(1, 5);
        for (i = 0; i < chars; i++) text_buf = {text_buf, 8'($urandom_range(0, 255))};
        random_items += text_buf.size();
        send_text();
      end else begin
        chars = $urandom_range(1, 8);
        for (i = 0; i < chars; i++) add_char($urandom_range(1, 4));
        if (kind < 40) add_truncated();
        random_items += text_buf.size();
        send_text();
      end
      if ($urandom_range(0, 39) == 0) wait_drain();
    end
    wait_drain();
  endtask

  // result sink: random ready pattern, long hold on request
  initial begin : result_sink
    int stall_left, run_left;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LongHold - 1;
        out_ready <= 1'b0;
      end else if (rx_nogap || run_left > 0) begin
        if (run_left > 0) run_left--;
        out_ready <= 1'b1;
      end else begin
        run_left = $urandom_range(0, 16);
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // compare each result beat with the oldest expected one
  always @(posedge clk) begin : check_results
    cp_result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: result with none expected, code_point %h", $time, out_code_point);
        errors++;
      end else begin
        exp_r = expected_points.pop_front();
        if (out_code_point !== exp_r.code_point) begin
          $display("%0t: code_point expected %h actual %h", $time, exp_r.code_point,
                   out_code_point);
          errors++;
        end
        if (out_has_point !== exp_r.has_point) begin
          $display("%0t: has_point expected %b actual %b", $time, exp_r.has_point,
                   out_has_point);
          errors++;
        end
        if (out_run_final !== exp_r.run_final) begin
          $display("%0t: run_final expected %b actual %b", $time, exp_r.run_final,
                   out_run_final);
          errors++;
        end
        if (out_text_done !== exp_r.text_done) begin
          $display("%0t: text_done expected %b actual %b", $time, exp_r.text_done,
                   out_text_done);
          errors++;
        end
      end
    end
  end

  // cycles since the last beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("%0t: no beat for %0d cycles", $time, IdleLimit);
    $display("[utf8_byte_stream_decoder] ERROR");
    $finish;
  end

  // test sequence
  initial begin : main_sequence
    int i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ascii_extremes();
    test_multibyte_extremes();
    test_stray_bytes();
    test_truncated_end();
    test_full_rate();
    test_output_backpressure();
    test_random_text();
    in_valid <= 1'b0;
    for (i = 0; i < IdleLimit && expected_points.size() != 0; i++) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (expected_points.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_points.size());
      errors++;
    end
    if (errors == 0)
      $display("[utf8_byte_stream_decoder] OK");
    else
      $display("[utf8_byte_stream_decoder] ERROR");
    $finish;
  end

endmodule
